### rtl/core/sa_pkg.sv
package sa_pkg;

  localparam int MaxSegs   = 64;
  localparam int IdxBits   = $clog2(MaxSegs);
  localparam int CntBits   = IdxBits + 1;
  localparam int SizeBits  = 16;
  localparam int OwnerBits = 8;
  localparam int EntBits   = SizeBits + OwnerBits;
  localparam logic [SizeBits-1:0] ResetTotal = SizeBits'(1024);

  localparam logic [1:0] PolFirst = 2'd0;
  localparam logic [1:0] PolNext  = 2'd1;
  localparam logic [1:0] PolBest  = 2'd2;
  localparam logic [1:0] PolWorst = 2'd3;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StNoOwner = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic RegPolicy = 1'b0;
  localparam logic RegTotal  = 1'b1;

  typedef struct packed {
    logic init_start;   // begin table clear
    logic load_req;     // capture request, reset scan
    logic scan_rd;      // issue read at scan address
    logic scan_eval;    // evaluate entry returned by read
    logic shift_rd;     // read entry just below shift address
    logic shift_wr;     // write read entry one slot up
    logic commit;       // write picked entry
    logic done;         // drive result strobe
  } sa_cmd_t;

  typedef struct packed {
    logic init_busy;
    logic scan_last;    // current eval is final entry, or request is invalid
    logic early_hit;    // first/next fit or release found match
    logic shift_last;   // shift reached pick+1
    logic need_shift;   // successful allocate with remainder and a free slot
  } sa_stat_t;

endpackage

### rtl/core/segment_allocator_fit_policies_top.sv
// Segment allocator: allocate (req_type 0) and release (req_type 1) requests
// are taken at an edge with start high and busy low. Each request reads the
// 64-entry segment table one entry at a time, examining all seg_count entries,
// except that first fit, next fit and release stop at the match. A split
// moves the entries above the pick up one slot and places the remainder.
// busy drops in the cycle the result is shown, so the next request can be
// taken at the edge that ends that cycle.
// After reset and after each total_size write taken while idle or clearing,
// the table is cleared, with busy high. The result appears for one cycle with
// done high; it cannot be stalled, so the receiver must take it on that cycle.
module segment_allocator_fit_policies_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [sa_pkg::SizeBits-1:0]  cfg_data,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type,
  input  logic [sa_pkg::OwnerBits-1:0] owner_id,
  input  logic [sa_pkg::SizeBits-1:0]  req_size,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [5:0]                   seg_index,
  output logic [sa_pkg::SizeBits-1:0]  free_total
);
  sa_pkg::sa_cmd_t  cmd;
  sa_pkg::sa_stat_t stat;
  logic total_wr, pol_wr;

  assign total_wr = cfg_we && (cfg_index == sa_pkg::RegTotal);
  assign pol_wr   = cfg_we && (cfg_index == sa_pkg::RegPolicy);

  sa_ctrl u_ctrl (
    .clk, .rst, .start, .cfg_total_wr(total_wr), .stat, .cmd, .busy
  );

  sa_dp u_dp (
    .clk, .rst, .cfg_policy_wr(pol_wr), .cfg_data,
    .req_type, .owner_id, .req_size, .cmd, .stat, .done,
    .status, .seg_index, .free_total
  );
endmodule

### rtl/core/sa_ram.sv
module sa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/sa_ctrl.sv
module sa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             cfg_total_wr,
  input  sa_pkg::sa_stat_t stat,
  output sa_pkg::sa_cmd_t  cmd,
  output logic             busy
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_SHRD  = 7'b0010000,
    S_SHWR  = 7'b0100000,
    S_COMMIT = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (cfg_total_wr) begin
          cmd.init_start = 1'b1;
          state_next = S_INIT;
        end else if (start) begin
          cmd.load_req = 1'b1;
          state_next = S_RD;
        end
      end
      S_INIT: begin
        if (cfg_total_wr) begin
          cmd.init_start = 1'b1;
        end else if (!stat.init_busy) begin
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        cmd.scan_rd = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.scan_eval = 1'b1;
        if (stat.early_hit || stat.scan_last) begin
          state_next = stat.need_shift ? S_SHRD : S_COMMIT;
        end else begin
          state_next = S_RD;
        end
      end
      S_SHRD: begin
        cmd.shift_rd = 1'b1;
        state_next = S_SHWR;
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_next = stat.shift_last ? S_COMMIT : S_SHRD;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

### rtl/core/sa_dp.sv
module sa_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_policy_wr,
  input  logic [sa_pkg::SizeBits-1:0]    cfg_data,
  input  logic                           req_type,
  input  logic [sa_pkg::OwnerBits-1:0]   owner_id,
  input  logic [sa_pkg::SizeBits-1:0]    req_size,
  input  sa_pkg::sa_cmd_t                cmd,
  output sa_pkg::sa_stat_t               stat,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [5:0]                     seg_index,
  output logic [sa_pkg::SizeBits-1:0]    free_total
);
  localparam int IB = sa_pkg::IdxBits;
  localparam int CB = sa_pkg::CntBits;
  localparam int SB = sa_pkg::SizeBits;
  localparam int OB = sa_pkg::OwnerBits;
  localparam logic [CB-1:0] MaxCnt = CB'(sa_pkg::MaxSegs);

  logic [1:0]    policy;
  logic [SB-1:0] total;
  logic [CB-1:0] seg_count;
  logic [IB-1:0] next_cursor;
  logic [SB-1:0] free_sum;

  logic          kind;
  logic [OB-1:0] owner;
  logic [SB-1:0] need;
  logic [IB-1:0] start_idx;
  logic [CB-1:0] k;
  logic [IB-1:0] addr;
  logic          found;
  logic [IB-1:0] pick;
  logic [SB-1:0] pick_size;
  logic [SB-1:0] best;
  logic          fail_early;
  logic [IB-1:0] sh_addr;

  logic [CB-1:0] init_cnt;
  logic          init_busy;

  logic          we;
  logic [IB-1:0] waddr, raddr;
  logic [sa_pkg::EntBits-1:0] wdata, rdata;
  logic [SB-1:0] r_size;
  logic [OB-1:0] r_owner;

  sa_ram #(.Width(sa_pkg::EntBits), .Depth(sa_pkg::MaxSegs)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign r_size  = rdata[sa_pkg::EntBits-1:OB];
  assign r_owner = rdata[OB-1:0];

  logic          is_free, fits, hit, better;
  logic [SB-1:0] rem;
  logic [CB-1:0] k_inc;
  logic          found_n;
  logic [IB-1:0] pick_n;
  logic [SB-1:0] psize_n, best_n;
  logic          last;

  always_comb begin
    is_free = (r_owner == '0);
    fits    = is_free && (r_size >= need);
    rem     = r_size - need;
    k_inc   = k + CB'(1);
    last    = (k_inc >= seg_count);
    hit     = 1'b0;
    better  = 1'b0;
    if (kind) begin
      hit = (r_owner == owner);
    end else begin
      case (policy)
        sa_pkg::PolFirst, sa_pkg::PolNext: hit = fits;
        sa_pkg::PolBest:  better = fits && (!found || rem < best);
        sa_pkg::PolWorst: better = is_free && (!found || r_size >= best);
        default: ;
      endcase
    end
    found_n = found;
    pick_n  = pick;
    psize_n = pick_size;
    best_n  = best;
    if (hit || better) begin
      found_n = 1'b1;
      pick_n  = addr;
      psize_n = r_size;
      best_n  = (policy == sa_pkg::PolWorst) ? r_size : rem;
    end
  end

  logic          fin_ok;
  logic [SB-1:0] fin_rem;
  always_comb begin
    fin_ok = found_n;
    if (!kind && policy == sa_pkg::PolWorst && psize_n < need) begin
      fin_ok = 1'b0;
    end
    if (fail_early) begin
      fin_ok = 1'b0;
    end
    fin_rem = psize_n - need;
  end

  assign stat.init_busy  = init_busy;
  assign stat.scan_last  = last || fail_early;
  assign stat.early_hit  = hit && !fail_early;
  assign stat.need_shift = !kind && fin_ok && (fin_rem != '0) && (seg_count < MaxCnt);
  assign stat.shift_last = (sh_addr == pick + IB'(1));

  logic [IB-1:0] a_calc;
  always_comb begin
    logic [CB-1:0] s;
    s = {1'b0, start_idx} + k;
    if (s >= seg_count) begin
      s = s - seg_count;
    end
    a_calc = s[IB-1:0];
  end

  logic          c_split;
  logic [IB-1:0] r_pick;
  logic [SB-1:0] r_psize;
  logic          r_ok;

  // the last shift step lands on pick+1 and writes the remainder there
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = addr;
    if (init_busy) begin
      we = 1'b1;
      waddr = init_cnt[IB-1:0];
      wdata = {(init_cnt == '0) ? total : SB'(0), OB'(0)};
    end else if (cmd.scan_rd) begin
      raddr = a_calc;
    end else if (cmd.shift_rd) begin
      raddr = sh_addr - IB'(1);
    end else if (cmd.shift_wr) begin
      we = 1'b1;
      waddr = sh_addr;
      wdata = (sh_addr == r_pick + IB'(1)) ? {r_psize - need, OB'(0)} : rdata;
    end else if (cmd.commit && r_ok) begin
      we = 1'b1;
      waddr = r_pick;
      if (kind) begin
        wdata = {r_psize, OB'(0)};
      end else begin
        wdata = {need, owner};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= 2'(sa_pkg::PolFirst);
      total       <= sa_pkg::ResetTotal;
      seg_count   <= CB'(1);
      next_cursor <= '0;
      free_sum    <= sa_pkg::ResetTotal;
      init_busy   <= 1'b1;
      init_cnt    <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_policy_wr) begin
        policy <= cfg_data[1:0];
      end
      if (cmd.init_start) begin
        total       <= cfg_data;
        seg_count   <= CB'(1);
        next_cursor <= '0;
        free_sum    <= cfg_data;
        init_busy   <= 1'b1;
        init_cnt    <= '0;
      end else if (init_busy) begin
        init_cnt <= init_cnt + CB'(1);
        if (init_cnt == MaxCnt - CB'(1)) begin
          init_busy <= 1'b0;
        end
      end
      if (cmd.load_req) begin
        kind  <= req_type;
        owner <= owner_id;
        need  <= req_size;
        k     <= '0;
        found <= 1'b0;
        pick  <= '0;
        best  <= '0;
        pick_size <= '0;
        fail_early <= (owner_id == '0) || (!req_type && req_size == '0);
        start_idx <= (!req_type && policy == sa_pkg::PolNext &&
                      {1'b0, next_cursor} < seg_count) ? next_cursor : '0;
      end
      if (cmd.scan_rd) begin
        addr <= a_calc;
      end
      if (cmd.scan_eval) begin
        k         <= k_inc;
        found     <= found_n;
        pick      <= pick_n;
        pick_size <= psize_n;
        best      <= best_n;
        r_ok      <= fin_ok;
        r_pick    <= pick_n;
        r_psize   <= psize_n;
        sh_addr   <= seg_count[IB-1:0];
        c_split   <= !kind && fin_ok && (fin_rem != '0);
        if (!kind && fin_ok && (fin_rem != '0) && seg_count >= MaxCnt) begin
          r_ok <= 1'b0;
          status <= sa_pkg::StFull;
          seg_index <= 6'(pick_n);
        end else if (fin_ok) begin
          status <= sa_pkg::StDone;
          seg_index <= 6'(pick_n);
        end else begin
          status <= (owner == '0 || kind) ? sa_pkg::StNoOwner : sa_pkg::StNoFit;
          seg_index <= '0;
        end
      end
      if (cmd.shift_wr) begin
        sh_addr <= sh_addr - IB'(1);
      end
      if (cmd.commit && r_ok) begin
        if (kind) begin
          free_sum <= free_sum + r_psize;
        end else begin
          free_sum <= free_sum - need;
          if (c_split) begin
            seg_count <= seg_count + CB'(1);
          end
          if (policy == sa_pkg::PolNext) begin
            next_cursor <= r_pick + IB'(1);
          end else if (c_split && {1'b0, next_cursor} < seg_count &&
                       next_cursor >= r_pick + IB'(1)) begin
            next_cursor <= next_cursor + IB'(1);
          end
        end
      end
      if (cmd.done) begin
        done <= 1'b1;
      end
    end
  end

  assign free_total = free_sum;
endmodule
